// ===== rtl/rtttl_pkg.sv =====
package rtttl_pkg;

  // Field widths
  localparam int CHAR_W   = 8;
  localparam int LEN_W    = 8;
  localparam int OCT_W    = 4;
  localparam int BPM_W    = 10;
  localparam int ACC_W    = 10;
  localparam int LETTER_W = 3;
  localparam int BASE_W   = 19;
  localparam int FREQ_W   = 23;
  localparam int DUR_W    = 19;
  localparam int PROD_W   = 18;
  localparam int QUO_W    = 18;

  // Widest pitch before saturation: base shifted up by at most 15 - 4 octaves
  localparam int OCT_BASE  = 4;
  localparam int MAX_SHIFT = 15 - OCT_BASE;
  localparam int SHIFT_W   = BASE_W + MAX_SHIFT;

  // Serial divider: quotient bits resolved per cycle and cycle count
  localparam int DIV_BITS   = 2;
  localparam int DIV_ITERS  = QUO_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_ITERS + 1);

  localparam logic [FREQ_W-1:0] FREQ_MAX     = FREQ_W'(8000000);
  localparam logic [QUO_W-1:0]  DUR_DIVIDEND = QUO_W'(240000);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_COLON = 8'd58;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'd44;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'd46;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'd35;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'd97;
  localparam logic [CHAR_W-1:0] CH_LO_G  = 8'd103;

  typedef enum logic [3:0] {
    PH_NAME       = 4'd0,
    PH_SKIP_D     = 4'd1,
    PH_DEF_LEN    = 4'd2,
    PH_WAIT_COMMA = 4'd3,
    PH_SKIP_O     = 4'd4,
    PH_DEF_OCT    = 4'd5,
    PH_SKIP_B     = 4'd6,
    PH_BPM        = 4'd7,
    PH_WAIT_COLON = 4'd8,
    PH_LEN        = 4'd9,
    PH_LETTER     = 4'd10,
    PH_SHARP      = 4'd11,
    PH_DOT1       = 4'd12,
    PH_OCT        = 4'd13,
    PH_DOT2       = 4'd14,
    PH_SEP        = 4'd15
  } phase_t;

  typedef enum logic [1:0] {
    C_IDLE = 2'd0,
    C_PREP = 2'd1,
    C_DIV  = 2'd2
  } ctrl_state_t;

  // Commands from the controller
  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Status from the note calculator
  typedef struct packed {
    logic div_done;
    logic out_free;
  } calc_stat_t;

  // Note captured by the parser when a token closes
  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [OCT_W-1:0]    oct;
    logic [LETTER_W-1:0] letter;
    logic                sharp;
    logic                dot;
    logic [BPM_W-1:0]    bpm;
    logic                song_end;
  } note_t;

  // Pitch tables in millihertz, letter 1..7 = a..g, 0 = no letter
  function automatic logic [BASE_W-1:0] natural_mhz(input logic [LETTER_W-1:0] l);
    logic [BASE_W-1:0] v;
    case (l)
      3'd1:    v = BASE_W'(220000);
      3'd2:    v = BASE_W'(246942);
      3'd3:    v = BASE_W'(261626);
      3'd4:    v = BASE_W'(293665);
      3'd5:    v = BASE_W'(329628);
      3'd6:    v = BASE_W'(349228);
      3'd7:    v = BASE_W'(391995);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [BASE_W-1:0] sharp_mhz(input logic [LETTER_W-1:0] l);
    logic [BASE_W-1:0] v;
    case (l)
      3'd1:    v = BASE_W'(233082);
      3'd3:    v = BASE_W'(277183);
      3'd4:    v = BASE_W'(311127);
      3'd6:    v = BASE_W'(369994);
      3'd7:    v = BASE_W'(415305);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/rtttl_note_parser_top.sv =====
// Ringtone text parser.
// in_*: one character per transaction, in_tdata = char_code, in_tlast marks the
// final character of the text. out_*: one note per transaction; out_tdata holds
// pitch in millihertz and duration in ms, out_tuser the rest and bad-tempo
// flags, out_tlast marks the note closed by the final character.
// A character that does not close a note leaves the controller idle, and the next
// one may follow in the next cycle. A character that closes a note starts the note
// calculation: the C_PREP state registers pitch and the tempo product, then a restoring
// divider resolves 2 quotient bits per cycle until all 18 bits are done. in_tready
// stays low from the accepting edge until the note is loaded into the output
// register, which raises out_tvalid.
// Reset puts the parser back into the header name phase with all defaults zero
// and drops any result not yet taken.
// If the receiver stalls, the result is held in the output register while the
// next characters are still taken; only a further note waits in the divider,
// with in_tready low, until the output register frees.
module rtttl_note_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [22:0] freq_millihertz, [41:23] duration_ms, zero fill
  output logic [1:0]  out_tuser,  // [0] is_rest, [1] bad_tempo
  output logic        out_tlast   // song_end
);
  import rtttl_pkg::*;

  cmd_t              cmd;
  calc_stat_t        stat;
  note_t             note;
  logic              emit_now;
  logic [FREQ_W-1:0] freq;
  logic [DUR_W-1:0]  dur;
  logic              rest, bad, song_end;

  // Sequence the accept, divide and output load
  rtttl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .emit_now  (emit_now),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Header and note token parsing, captures a note when a token closes
  rtttl_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .char_code (in_tdata[CHAR_W-1:0]),
    .last_char (in_tlast),
    .emit_now  (emit_now),
    .note      (note)
  );

  // Pitch, tempo division and the output register
  rtttl_calc u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .note       (note),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_freq   (freq),
    .out_dur    (dur),
    .out_rest   (rest),
    .out_bad    (bad),
    .out_end    (song_end)
  );

  assign out_tdata = {6'b0, dur, freq};
  assign out_tuser = {bad, rest};
  assign out_tlast = song_end;

endmodule

// ===== rtl/rtttl_parse.sv =====
module rtttl_parse (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rtttl_pkg::cmd_t                 cmd,
  input  logic [rtttl_pkg::CHAR_W-1:0]    char_code,
  input  logic                            last_char,
  output logic                            emit_now,
  output rtttl_pkg::note_t                note
);
  import rtttl_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [LEN_W-1:0]    dlen_r, dlen_nxt;
  logic [OCT_W-1:0]    doct_r, doct_nxt;
  logic [BPM_W-1:0]    bpm_r, bpm_nxt;
  logic [LEN_W-1:0]    nlen_r, nlen_nxt;
  logic [OCT_W-1:0]    noct_r, noct_nxt;
  logic [LETTER_W-1:0] letter_r, letter_nxt;
  logic                sharp_r, sharp_nxt;
  logic                dot_r, dot_nxt;
  logic                slen_r, slen_nxt;
  logic                soct_r, soct_nxt;
  note_t               note_r, note_nxt;

  // Updated values for this character, before any clear
  phase_t              ph_u;
  logic [ACC_W-1:0]    acc_u;
  logic [LEN_W-1:0]    dlen_u;
  logic [OCT_W-1:0]    doct_u;
  logic [BPM_W-1:0]    bpm_u;
  logic [LEN_W-1:0]    nlen_u;
  logic [OCT_W-1:0]    noct_u;
  logic [LETTER_W-1:0] letter_u;
  logic                sharp_u, dot_u, slen_u, soct_u;
  logic                done;

  logic                is_dig, is_letter;
  logic [3:0]          digv;
  logic [LETTER_W-1:0] letter_c;
  logic [ACC_W-1:0]    acc_dec, acc_sum, nlen_sum, noct_sum;

  function automatic logic [ACC_W-1:0] acc_sat(input logic [ACC_W-1:0] acc,
                                               input logic [3:0] d,
                                               input logic [ACC_W-1:0] lim);
    logic [ACC_W+3:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{ACC_W{1'b0}}, d};
    return (v > {4'b0, lim}) ? lim : v[ACC_W-1:0];
  endfunction

  assign is_dig    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign digv      = char_code[3:0];
  assign is_letter = (char_code >= CH_LO_A) && (char_code <= CH_LO_G);
  assign letter_c  = is_letter ? char_code[LETTER_W-1:0] : '0;
  assign acc_dec   = (acc_r != '0) ? acc_r - ACC_W'(1) : '0;
  assign acc_sum   = acc_sat(acc_r, digv, ACC_W'(1023));
  assign nlen_sum  = acc_sat(ACC_W'(nlen_r), digv, ACC_W'(255));
  assign noct_sum  = acc_sat(ACC_W'(noct_r), digv, ACC_W'(15));

  always_comb begin
    ph_u     = phase_r;
    acc_u    = acc_r;
    dlen_u   = dlen_r;
    doct_u   = doct_r;
    bpm_u    = bpm_r;
    nlen_u   = nlen_r;
    noct_u   = noct_r;
    letter_u = letter_r;
    sharp_u  = sharp_r;
    dot_u    = dot_r;
    slen_u   = slen_r;
    soct_u   = soct_r;
    done     = 1'b0;
    case (phase_r)
      PH_NAME: begin
        if (char_code == CH_COLON) begin
          ph_u  = PH_SKIP_D;
          acc_u = ACC_W'(2);
        end
      end
      PH_SKIP_D, PH_SKIP_O, PH_SKIP_B: begin
        acc_u = acc_dec;
        if (acc_dec == '0) ph_u = phase_t'(4'(phase_r) + 4'd1);
      end
      PH_DEF_LEN: begin
        if (is_dig) begin
          acc_u = acc_sum;
        end else begin
          dlen_u = (acc_r > ACC_W'(255)) ? '1 : acc_r[LEN_W-1:0];
          acc_u  = '0;
          if (char_code == CH_COMMA) begin
            ph_u  = PH_SKIP_O;
            acc_u = ACC_W'(2);
          end else begin
            ph_u = PH_WAIT_COMMA;
          end
        end
      end
      PH_WAIT_COMMA: begin
        if (char_code == CH_COMMA) begin
          ph_u  = PH_SKIP_O;
          acc_u = ACC_W'(2);
        end
      end
      PH_DEF_OCT: begin
        doct_u = is_dig ? digv : '0;
        ph_u   = PH_SKIP_B;
        acc_u  = ACC_W'(3);
      end
      PH_BPM: begin
        if (is_dig) begin
          acc_u = acc_sum;
        end else begin
          bpm_u = acc_r;
          acc_u = '0;
          ph_u  = (char_code == CH_COLON) ? PH_LEN : PH_WAIT_COLON;
        end
      end
      PH_WAIT_COLON: begin
        if (char_code == CH_COLON) ph_u = PH_LEN;
      end
      PH_LEN: begin
        if (is_dig) begin
          nlen_u = nlen_sum[LEN_W-1:0];
          slen_u = 1'b1;
        end else if (char_code == CH_DOT) begin
          dot_u = 1'b1;
          ph_u  = PH_LETTER;
        end else begin
          letter_u = letter_c;
          ph_u     = PH_SHARP;
        end
      end
      PH_LETTER: begin
        letter_u = letter_c;
        ph_u     = PH_SHARP;
      end
      PH_SHARP, PH_DOT1, PH_OCT, PH_DOT2: begin
        // Each phase also takes what the later phases would take
        if (phase_r == PH_SHARP && char_code == CH_HASH) begin
          sharp_u = 1'b1;
          ph_u    = PH_DOT1;
        end else if (phase_r <= PH_DOT1 && char_code == CH_DOT) begin
          dot_u = 1'b1;
          ph_u  = PH_OCT;
        end else if (phase_r <= PH_OCT && is_dig) begin
          noct_u = noct_sum[OCT_W-1:0];
          soct_u = 1'b1;
          ph_u   = PH_OCT;
        end else if (char_code == CH_DOT) begin
          dot_u = 1'b1;
          ph_u  = PH_SEP;
        end else begin
          done = 1'b1;
          ph_u = PH_LEN;
        end
      end
      default: begin
        done = 1'b1;
        ph_u = PH_LEN;
      end
    endcase
  end

  // A token closes on its separator, or on the last character once notes began
  assign emit_now = done || (last_char && ph_u >= PH_LEN);

  always_comb begin
    note_nxt          = note_r;
    note_nxt.len      = slen_u ? nlen_u : dlen_u;
    note_nxt.oct      = soct_u ? noct_u : doct_u;
    note_nxt.letter   = letter_u;
    note_nxt.sharp    = sharp_u;
    note_nxt.dot      = dot_u;
    note_nxt.bpm      = bpm_u;
    note_nxt.song_end = last_char;
  end

  always_comb begin
    phase_nxt  = ph_u;
    acc_nxt    = acc_u;
    dlen_nxt   = dlen_u;
    doct_nxt   = doct_u;
    bpm_nxt    = bpm_u;
    nlen_nxt   = nlen_u;
    noct_nxt   = noct_u;
    letter_nxt = letter_u;
    sharp_nxt  = sharp_u;
    dot_nxt    = dot_u;
    slen_nxt   = slen_u;
    soct_nxt   = soct_u;
    if (last_char) begin
      phase_nxt = PH_NAME;
      acc_nxt   = '0;
      dlen_nxt  = '0;
      doct_nxt  = '0;
      bpm_nxt   = '0;
    end
    if (last_char || done) begin
      nlen_nxt   = '0;
      noct_nxt   = '0;
      letter_nxt = '0;
      sharp_nxt  = 1'b0;
      dot_nxt    = 1'b0;
      slen_nxt   = 1'b0;
      soct_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_NAME;
      acc_r    <= '0;
      dlen_r   <= '0;
      doct_r   <= '0;
      bpm_r    <= '0;
      nlen_r   <= '0;
      noct_r   <= '0;
      letter_r <= '0;
      sharp_r  <= 1'b0;
      dot_r    <= 1'b0;
      slen_r   <= 1'b0;
      soct_r   <= 1'b0;
    end else if (cmd.accept) begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      dlen_r   <= dlen_nxt;
      doct_r   <= doct_nxt;
      bpm_r    <= bpm_nxt;
      nlen_r   <= nlen_nxt;
      noct_r   <= noct_nxt;
      letter_r <= letter_nxt;
      sharp_r  <= sharp_nxt;
      dot_r    <= dot_nxt;
      slen_r   <= slen_nxt;
      soct_r   <= soct_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && emit_now) note_r <= note_nxt;
  end

  assign note = note_r;

endmodule

// ===== rtl/rtttl_calc.sv =====
module rtttl_calc (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rtttl_pkg::cmd_t                 cmd,
  input  rtttl_pkg::note_t                note,
  output rtttl_pkg::calc_stat_t           stat,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rtttl_pkg::FREQ_W-1:0]    out_freq,
  output logic [rtttl_pkg::DUR_W-1:0]     out_dur,
  output logic                            out_rest,
  output logic                            out_bad,
  output logic                            out_end
);
  import rtttl_pkg::*;

  logic [PROD_W-1:0]    prod;
  logic [BASE_W-1:0]    base;
  logic [OCT_W-1:0]     shamt;
  logic [SHIFT_W-1:0]   shifted;
  logic [FREQ_W-1:0]    freq;

  logic [PROD_W-1:0]    div_r;
  logic [QUO_W-1:0]     rem_r, rem_nxt;
  logic [QUO_W-1:0]     quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [FREQ_W-1:0]    freq_r;
  logic                 rest_r, bad_r, dot_r, end_r;

  logic [QUO_W:0]       trial;
  logic [DUR_W-1:0]     dur;

  logic                 out_tvalid_r;
  logic [FREQ_W-1:0]    out_freq_r;
  logic [DUR_W-1:0]     out_dur_r;
  logic                 out_rest_r, out_bad_r, out_end_r;

  assign prod    = PROD_W'(note.bpm) * PROD_W'(note.len);
  assign base    = note.sharp ? sharp_mhz(note.letter) : natural_mhz(note.letter);
  assign shamt   = (note.oct > OCT_W'(OCT_BASE)) ? note.oct - OCT_W'(OCT_BASE) : '0;
  assign shifted = SHIFT_W'(base) << shamt;
  assign freq    = (shifted > SHIFT_W'(FREQ_MAX)) ? FREQ_MAX : shifted[FREQ_W-1:0];

  // Restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial   = {rem_nxt, quo_nxt[QUO_W-1]};
      quo_nxt = {quo_nxt[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        trial      = trial - {1'b0, div_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[QUO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_r  <= prod;
      rem_r  <= '0;
      quo_r  <= DUR_DIVIDEND;
      freq_r <= freq;
      rest_r <= (base == '0);
      bad_r  <= (prod == '0);
      dot_r  <= note.dot;
      end_r  <= note.song_end;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_start) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  // Dotted note: d + d/2
  assign dur = bad_r ? '0
             : DUR_W'(quo_r) + (dot_r ? DUR_W'(quo_r[QUO_W-1:1]) : '0);

  assign stat.div_done = (cnt_r == DIV_CNT_W'(DIV_ITERS));
  assign stat.out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_freq_r <= freq_r;
      out_dur_r  <= dur;
      out_rest_r <= rest_r;
      out_bad_r  <= bad_r;
      out_end_r  <= end_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_freq   = out_freq_r;
  assign out_dur    = out_dur_r;
  assign out_rest   = out_rest_r;
  assign out_bad    = out_bad_r;
  assign out_end    = out_end_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over a pending result");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_bad_r |-> out_dur_r == '0)
    else $error("bad tempo with nonzero duration");

  a_rest_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_rest_r |-> out_freq_r == '0)
    else $error("rest with nonzero pitch");

endmodule

// ===== rtl/rtttl_ctrl.sv =====
module rtttl_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic                   emit_now,
  input  rtttl_pkg::calc_stat_t  stat,
  output rtttl_pkg::cmd_t        cmd
);
  import rtttl_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE: if (in_tvalid && emit_now) state_nxt = C_PREP;
      C_PREP: state_nxt = C_DIV;
      C_DIV:  if (stat.div_done && stat.out_free) state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      C_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      C_PREP: cmd.div_start = 1'b1;
      C_DIV: begin
        cmd.div_step = !stat.div_done;
        cmd.out_load = stat.div_done && stat.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_prep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && emit_now |=> state_r == C_PREP)
    else $error("closing token did not start the note calculation");

endmodule

// ===== dv/rtttl_note_checker.sv =====
`timescale 1ns / 1ps
module rtttl_note_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          n_pending,
  output int          n_errors,
  output int          n_notes,
  output int          n_rests,
  output int          n_bad_tempo,
  output int          n_song_ends
);
  import rtttl_pkg::*;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
    logic              rest;
    logic              bad_tempo;
    logic              song_end;
  } note_result_t;

  note_result_t expected_q[$];

  // Parser state
  phase_t              pstate;
  logic [LEN_W-1:0]    dflt_len;
  logic [OCT_W-1:0]    dflt_oct;
  logic [BPM_W-1:0]    tempo;
  logic [ACC_W-1:0]    num_acc;
  logic [LEN_W-1:0]    tok_len;
  logic [OCT_W-1:0]    tok_oct;
  logic [LETTER_W-1:0] tok_letter;
  logic                tok_sharp;
  logic                tok_dot;
  logic                tok_has_len;
  logic                tok_has_oct;

  // Pitch in millihertz by {sharp, letter}; missing entries have no pitch
  function automatic logic [BASE_W-1:0] pitch_mhz(input logic [LETTER_W-1:0] l,
                                                  input logic s);
    logic [BASE_W-1:0] p;
    case ({s, l})
      4'h1:    p = 19'd220000;
      4'h2:    p = 19'd246942;
      4'h3:    p = 19'd261626;
      4'h4:    p = 19'd293665;
      4'h5:    p = 19'd329628;
      4'h6:    p = 19'd349228;
      4'h7:    p = 19'd391995;
      4'h9:    p = 19'd233082;
      4'hB:    p = 19'd277183;
      4'hC:    p = 19'd311127;
      4'hE:    p = 19'd369994;
      4'hF:    p = 19'd415305;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic int add_digit(input int a, input logic [7:0] c, input int lim);
    int v;
    v = a * 10 + int'(c) - int'(CH_ZERO);
    return (v > lim) ? lim : v;
  endfunction

  task automatic clear_token();
    tok_len     = '0;
    tok_oct     = '0;
    tok_letter  = '0;
    tok_sharp   = 1'b0;
    tok_dot     = 1'b0;
    tok_has_len = 1'b0;
    tok_has_oct = 1'b0;
  endtask

  task automatic reset_parser();
    pstate   = PH_NAME;
    dflt_len = '0;
    dflt_oct = '0;
    tempo    = '0;
    num_acc  = '0;
    clear_token();
  endtask

  // Close the current token and queue the note it describes
  task automatic close_note(input logic fin);
    logic [LEN_W-1:0]  len;
    logic [OCT_W-1:0]  oct;
    logic [BASE_W-1:0] base;
    longint unsigned   f;
    int unsigned       prod;
    int unsigned       dur;
    note_result_t      r;
    len  = tok_has_len ? tok_len : dflt_len;
    oct  = tok_has_oct ? tok_oct : dflt_oct;
    base = pitch_mhz(tok_letter, tok_sharp);
    f    = base;
    // only octaves above the base raise the pitch
    if (oct > OCT_BASE) f = f << (oct - OCT_BASE);
    if (f > FREQ_MAX) f = FREQ_MAX;
    prod = 32'(tempo) * 32'(len);
    dur  = 0;
    if (prod != 0) begin
      dur = 240000 / prod;
      if (tok_dot) dur = dur + dur / 2;
    end
    r.freq      = f[FREQ_W-1:0];
    r.dur       = dur[DUR_W-1:0];
    r.rest      = (base == '0);
    r.bad_tempo = (prod == 0);
    r.song_end  = fin;
    expected_q.push_back(r);
    clear_token();
  endtask

  task automatic parse_char(input logic [7:0] c, input logic fin);
    logic digit;
    logic fired;
    logic handled;
    digit   = (c >= CH_ZERO) && (c <= CH_NINE);
    fired   = 1'b0;
    handled = 1'b0;
    case (pstate)
      PH_NAME: begin
        if (c == CH_COLON) begin
          pstate  = PH_SKIP_D;
          num_acc = 10'd2;
        end
      end
      PH_SKIP_D, PH_SKIP_O, PH_SKIP_B: begin
        if (num_acc != '0) num_acc = num_acc - 1'b1;
        if (num_acc == '0) pstate = phase_t'(pstate + 1);
      end
      PH_DEF_LEN: begin
        if (digit) begin
          num_acc = ACC_W'(add_digit(int'(num_acc), c, 1023));
        end else begin
          dflt_len = (num_acc > 10'd255) ? 8'd255 : num_acc[LEN_W-1:0];
          num_acc  = '0;
          if (c == CH_COMMA) begin
            pstate  = PH_SKIP_O;
            num_acc = 10'd2;
          end else begin
            pstate = PH_WAIT_COMMA;
          end
        end
      end
      PH_WAIT_COMMA: begin
        if (c == CH_COMMA) begin
          pstate  = PH_SKIP_O;
          num_acc = 10'd2;
        end
      end
      PH_DEF_OCT: begin
        dflt_oct = digit ? OCT_W'(c - CH_ZERO) : '0;
        pstate   = PH_SKIP_B;
        num_acc  = 10'd3;
      end
      PH_BPM: begin
        if (digit) begin
          num_acc = ACC_W'(add_digit(int'(num_acc), c, 1023));
        end else begin
          tempo   = num_acc;
          num_acc = '0;
          pstate  = (c == CH_COLON) ? PH_LEN : PH_WAIT_COLON;
        end
      end
      PH_WAIT_COLON: begin
        if (c == CH_COLON) pstate = PH_LEN;
      end
      PH_LEN, PH_LETTER: begin
        if (pstate == PH_LEN && digit) begin
          tok_len     = LEN_W'(add_digit(int'(tok_len), c, 255));
          tok_has_len = 1'b1;
        end else if (pstate == PH_LEN && c == CH_DOT) begin
          tok_dot = 1'b1;
          pstate  = PH_LETTER;
        end else begin
          tok_letter = (c >= CH_LO_A && c <= CH_LO_G) ? LETTER_W'(c - CH_LO_A + 1) : '0;
          pstate     = PH_SHARP;
        end
      end
      default: begin
        // Token tail: each phase also accepts what the later phases accept
        if (pstate == PH_SHARP && c == CH_HASH) begin
          tok_sharp = 1'b1;
          pstate    = PH_DOT1;
          handled   = 1'b1;
        end
        if (!handled && pstate <= PH_DOT1 && c == CH_DOT) begin
          tok_dot = 1'b1;
          pstate  = PH_OCT;
          handled = 1'b1;
        end
        if (!handled && pstate <= PH_OCT && digit) begin
          tok_oct     = OCT_W'(add_digit(int'(tok_oct), c, 15));
          tok_has_oct = 1'b1;
          pstate      = PH_OCT;
          handled     = 1'b1;
        end
        if (!handled && pstate <= PH_DOT2 && c == CH_DOT) begin
          tok_dot = 1'b1;
          pstate  = PH_SEP;
          handled = 1'b1;
        end
        // anything else is the separator
        if (!handled) begin
          close_note(fin);
          pstate = PH_LEN;
          fired  = 1'b1;
        end
      end
    endcase
    if (fin) begin
      if (!fired && pstate >= PH_LEN) close_note(1'b1);
      reset_parser();
    end
  endtask

  task automatic report(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    note_result_t got;
    note_result_t want;
    if (!rst_n) begin
      reset_parser();
      expected_q.delete();
      n_errors    = 0;
      n_notes     = 0;
      n_rests     = 0;
      n_bad_tempo = 0;
      n_song_ends = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.freq      = out_tdata[22:0];
        got.dur       = out_tdata[41:23];
        got.rest      = out_tuser[0];
        got.bad_tempo = out_tuser[1];
        got.song_end  = out_tlast;
        n_notes++;
        if (got.rest)      n_rests++;
        if (got.bad_tempo) n_bad_tempo++;
        if (got.song_end)  n_song_ends++;
        if (expected_q.size() == 0) begin
          report($sformatf("note with none pending: freq=%0d dur=%0d rest=%0b bad=%0b end=%0b",
                           got.freq, got.dur, got.rest, got.bad_tempo, got.song_end));
        end else begin
          want = expected_q.pop_front();
          if (got.freq !== want.freq || got.dur !== want.dur || got.rest !== want.rest ||
              got.bad_tempo !== want.bad_tempo || got.song_end !== want.song_end) begin
            report($sformatf({"note %0d: exp freq=%0d dur=%0d rest=%0b bad=%0b end=%0b,",
                              " got freq=%0d dur=%0d rest=%0b bad=%0b end=%0b"},
                             n_notes, want.freq, want.dur, want.rest, want.bad_tempo,
                             want.song_end, got.freq, got.dur, got.rest, got.bad_tempo,
                             got.song_end));
          end
        end
      end
      if (in_tvalid && in_tready) parse_char(in_tdata, in_tlast);
    end
    // registered so the stimulus side reads a settled value at the edge
    n_pending <= expected_q.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import rtttl_pkg::*;

  localparam int N_CHARS       = 1200;   // stop making texts after this many characters
  localparam int IDLE_LIMIT    = 3000;   // cycles with no transaction on either side
  localparam int SETTLE_CYCLES = 24;     // quiet time after the last note, > note latency

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int n_pending;
  int n_errors;
  int n_notes;
  int n_rests;
  int n_bad_tempo;
  int n_song_ends;

  int   chars_sent  = 0;
  int   texts_sent  = 0;
  int   header_cuts = 0;
  int   noise_texts = 0;
  int   rx_hold     = 0;
  int   idle_cycles = 0;
  bit   tx_gappy    = 1'b0;
  logic rx_stalls   = 1'b0;

  // characters of the text being built
  logic [7:0] text_q[$];

  initial begin
    forever #10 clk = ~clk;
  end

  rtttl_note_parser_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  rtttl_note_checker u_note_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .n_pending   (n_pending),
    .n_errors    (n_errors),
    .n_notes     (n_notes),
    .n_rests     (n_rests),
    .n_bad_tempo (n_bad_tempo),
    .n_song_ends (n_song_ends)
  );

  // Receiver: hold tready for a random stretch, mostly short, now and then long.
  // With stalls off, stay ready every cycle.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else if (!rx_stalls) begin
      out_tready <= 1'b1;
    end else if (r < 65) begin
      out_tready <= 1'b1;
      rx_hold    <= $urandom_range(0, 4);
    end else if (r < 93) begin
      out_tready <= 1'b0;
      rx_hold    <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b0;
      rx_hold    <= $urandom_range(15, 50);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_gappy || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] any_but(input logic [7:0] avoid);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == avoid);
    return c;
  endfunction

  // a field terminator must not look like another digit
  function automatic logic [7:0] non_digit_but(input logic [7:0] avoid);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == avoid || (c >= CH_ZERO && c <= CH_NINE));
    return c;
  endfunction

  // Send one character; tvalid stays high into the next transaction when there is no gap
  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    texts_sent++;
  endtask

  // Drop tvalid and hold until every predicted note has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  task automatic push_number(input int n);
    bit nines;
    nines = ($urandom_range(0, 4) == 0);
    repeat (n) text_q.push_back(nines ? CH_NINE : 8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  // fixed-offset skip: usually the usual key text, sometimes arbitrary bytes
  task automatic push_skip(input string usual);
    bit keep;
    keep = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < usual.len(); i++)
      text_q.push_back(keep ? usual[i] : 8'($urandom_range(0, 255)));
  endtask

  // end a header number, either directly or via junk that the parser skips
  task automatic push_field_end(input logic [7:0] term);
    if ($urandom_range(0, 4) != 0) begin
      text_q.push_back(term);
    end else begin
      text_q.push_back(non_digit_but(term));
      repeat ($urandom_range(0, 2)) text_q.push_back(any_but(term));
      text_q.push_back(term);
    end
  endtask

  function automatic int pick_count(input int lo, input int hi, input int rare_hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 85) return $urandom_range(lo, hi);
    return $urandom_range(hi + 1, rare_hi);
  endfunction

  // [digits][.]letter[#][.][digits][.] then a separator when with_sep is set
  task automatic push_note(input bit with_sep);
    int r;
    if ($urandom_range(0, 1) == 0) push_number($urandom_range(1, 3));
    if ($urandom_range(0, 6) == 0) text_q.push_back(CH_DOT);
    r = $urandom_range(0, 99);
    if (r < 75)      text_q.push_back(8'(CH_LO_A + $urandom_range(0, 6)));
    else if (r < 85) text_q.push_back("p");
    else             text_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) < 3) text_q.push_back(CH_HASH);
    if ($urandom_range(0, 6) == 0) text_q.push_back(CH_DOT);
    if ($urandom_range(0, 1) == 0) push_number($urandom_range(1, 2));
    if ($urandom_range(0, 6) == 0) text_q.push_back(CH_DOT);
    if (with_sep)
      text_q.push_back(($urandom_range(0, 99) < 85) ? CH_COMMA : 8'($urandom_range(0, 255)));
  endtask

  // Build a text of header and notes with random content; return the header length
  task automatic make_song(output int hdr_len);
    int n_notes_txt;
    text_q.delete();
    repeat ($urandom_range(0, 5)) text_q.push_back(any_but(CH_COLON));
    text_q.push_back(CH_COLON);
    push_skip("d=");
    push_number(pick_count(1, 2, 4));
    push_field_end(CH_COMMA);
    push_skip("o=");
    if ($urandom_range(0, 4) != 0) text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    else                           text_q.push_back(8'($urandom_range(0, 255)));
    push_skip(",b=");
    push_number(pick_count(2, 3, 5));
    push_field_end(CH_COLON);
    hdr_len = text_q.size();
    n_notes_txt = $urandom_range(1, 8);
    for (int i = 0; i < n_notes_txt; i++)
      push_note(i < n_notes_txt - 1 || $urandom_range(0, 1) == 0);
  endtask

  initial begin
    int r;
    int hdr_len;
    int cut;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: text ending inside the header (no note), then one text with saturated
    // length, bpm and octave, a non-digit default octave, dots in every slot, a sharp
    // that has no pitch, a rest, an uppercase letter, and a note closed by the last char.
    send_str(":d");
    send_str(":d=999,o=x,b=99999:999.g#.99.,b#,p,Z,c");
    wait_drained();

    while (chars_sent < N_CHARS) begin
      tx_gappy   = ($urandom_range(0, 3) != 0);
      rx_stalls <= ($urandom_range(0, 9) < 7);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        // pure noise, mostly stuck in the header
        text_q.delete();
        repeat ($urandom_range(3, 20)) text_q.push_back(8'($urandom_range(0, 255)));
        cut = text_q.size() - 1;
        noise_texts++;
      end else begin
        make_song(hdr_len);
        if (r < 14) begin
          cut = $urandom_range(0, hdr_len - 1);
          header_cuts++;
        end else begin
          cut = text_q.size() - 1;
        end
      end
      for (int i = 0; i <= cut; i++) send_char(text_q[i], i == cut);
      texts_sent++;
      if ($urandom_range(0, 4) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d texts (%0d cut in the header, %0d noise).",
             chars_sent, texts_sent, header_cuts, noise_texts);
    $display("Checked %0d notes: %0d rests, %0d with zero tempo, %0d closing a text.",
             n_notes, n_rests, n_bad_tempo, n_song_ends);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== rtttl_note_parser_top.f =====
rtl/rtttl_pkg.sv
rtl/rtttl_parse.sv
rtl/rtttl_calc.sv
rtl/rtttl_ctrl.sv
rtl/rtttl_note_parser_top.sv
dv/rtttl_note_checker.sv
dv/tb.sv
